FILE: hw/rtl/bdc_pkg.sv
// Shared types and constants for the button debounce and click detector.
`default_nettype none

package bdc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned CLK_W  = 2;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS    = 2'd0;
    localparam logic [IDX_W-1:0] REG_CLICK_WINDOW   = 2'd1;
    localparam logic [IDX_W-1:0] REG_DOUBLE_TIMEOUT = 2'd2;

    // Register values after reset
    localparam logic [CFG_W-1:0] RST_DEBOUNCE_MS    = 16'd50;
    localparam logic [CFG_W-1:0] RST_CLICK_WINDOW   = 16'd700;
    localparam logic [CFG_W-1:0] RST_DOUBLE_TIMEOUT = 16'd700;

    // Click count at which a double click is declared
    localparam logic [CLK_W-1:0] CLICKS_DOUBLE = 2'd2;

    typedef struct packed {
        logic pin_level;
        logic ack_press;
        logic ack_release;
        logic ack_double;
        logic clear_all;
    } t_item;

    typedef struct packed {
        logic              held;
        logic              press_event;
        logic              release_event;
        logic              double_event;
        logic [TIME_W-1:0] press_length;
        logic [TIME_W-1:0] press_timestamp;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] click_window;
        logic [CFG_W-1:0] double_timeout;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hw/rtl/bdc_state.sv
// Debounce, edge, click state and the per-tick update logic.
`default_nettype none

module bdc_state
    import bdc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    logic [TIME_W-1:0] r_now, n_now;
    logic              r_raw_prev, n_raw_prev;
    logic              r_stable, n_stable;
    logic [TIME_W-1:0] r_change_time, n_change_time;
    logic              r_press_flag, n_press_flag;
    logic              r_release_flag, n_release_flag;
    logic [TIME_W-1:0] r_press_start, n_press_start;
    logic [TIME_W-1:0] r_last_press, n_last_press;
    logic [TIME_W-1:0] r_last_duration, n_last_duration;
    logic [TIME_W-1:0] r_last_click, n_last_click;
    logic [CLK_W-1:0]  r_clicks, n_clicks;
    logic              r_double_flag, n_double_flag;

    logic              raw;
    logic              edge_seen;
    logic              consec;
    logic [CLK_W-1:0]  clicks_inc;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_click;
    logic [TIME_W-1:0] idle_time;
    logic [TIME_W-1:0] held_time;

    // Values after the debounce and edge update, before acknowledges
    logic              m_press_flag;
    logic              m_release_flag;
    logic [TIME_W-1:0] m_last_duration;
    logic [CLK_W-1:0]  m_clicks;
    logic              m_double_flag;

    always_comb begin
        raw           = ~i_item.pin_level;
        n_now         = r_now + 32'd1;
        n_raw_prev    = raw;
        n_change_time = (raw != r_raw_prev) ? r_now : r_change_time;
        since_change  = r_now - n_change_time;
        edge_seen     = (since_change > {16'd0, i_cfg.debounce_ms}) && (raw != r_stable);
        n_stable      = edge_seen ? raw : r_stable;

        m_press_flag    = r_press_flag;
        m_release_flag  = r_release_flag;
        m_last_duration = r_last_duration;
        m_clicks        = r_clicks;
        m_double_flag   = r_double_flag;
        n_press_start   = r_press_start;
        n_last_press    = r_last_press;
        n_last_click    = r_last_click;

        since_click = r_now - r_last_click;
        consec      = since_click < {16'd0, i_cfg.click_window};
        clicks_inc  = r_clicks + 2'd1;

        if (edge_seen && raw) begin
            m_press_flag  = 1'b1;
            n_press_start = r_now;
            n_last_press  = r_now;
        end else if (edge_seen) begin
            m_release_flag  = 1'b1;
            m_last_duration = r_now - r_press_start;
            if (consec) begin
                if (clicks_inc >= CLICKS_DOUBLE) begin
                    m_double_flag = 1'b1;
                    m_clicks      = '0;
                end else begin
                    m_clicks = clicks_inc;
                end
            end else begin
                m_clicks = 2'd1;
            end
            n_last_click = r_now;
        end

        held_time = r_now - n_press_start;

        o_result.held            = n_stable;
        o_result.press_event     = m_press_flag;
        o_result.release_event   = m_release_flag;
        o_result.double_event    = m_double_flag;
        o_result.press_length    = n_stable ? held_time : m_last_duration;
        o_result.press_timestamp = n_last_press;

        // Apply acknowledges after the result is formed
        idle_time       = r_now - n_last_click;
        n_press_flag    = m_press_flag & ~i_item.ack_press;
        n_release_flag  = m_release_flag & ~i_item.ack_release;
        n_double_flag   = m_double_flag & ~i_item.ack_double;
        n_clicks        = m_clicks;
        n_last_duration = m_last_duration;
        if (i_item.ack_double && (idle_time > {16'd0, i_cfg.double_timeout})) begin
            n_clicks = '0;
        end
        if (i_item.clear_all) begin
            n_press_flag    = 1'b0;
            n_release_flag  = 1'b0;
            n_double_flag   = 1'b0;
            n_clicks        = '0;
            n_last_duration = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now           <= '0;
            r_raw_prev      <= 1'b0;
            r_stable        <= 1'b0;
            r_change_time   <= '0;
            r_press_flag    <= 1'b0;
            r_release_flag  <= 1'b0;
            r_press_start   <= '0;
            r_last_press    <= '0;
            r_last_duration <= '0;
            r_last_click    <= '0;
            r_clicks        <= '0;
            r_double_flag   <= 1'b0;
        end else if (i_step) begin
            r_now           <= n_now;
            r_raw_prev      <= n_raw_prev;
            r_stable        <= n_stable;
            r_change_time   <= n_change_time;
            r_press_flag    <= n_press_flag;
            r_release_flag  <= n_release_flag;
            r_press_start   <= n_press_start;
            r_last_press    <= n_last_press;
            r_last_duration <= n_last_duration;
            r_last_click    <= n_last_click;
            r_clicks        <= n_clicks;
            r_double_flag   <= n_double_flag;
        end
    end

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.clear_all |=>
            !r_press_flag && !r_release_flag && !r_double_flag && (r_clicks == '0)
            && (r_last_duration == '0))
        else $error("clear_all left event state behind");

    a_clicks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clicks < CLICKS_DOUBLE)
        else $error("click count reached the double-click value");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_now == $past(r_now) + 32'd1)
        else $error("millisecond counter failed to advance on an item");

endmodule

`default_nettype wire

FILE: hw/rtl/button_debounce_click_detector.sv
// Top level: handshake registers, configuration registers and the state core.
//
// Use: each input item is one millisecond tick carrying the raw active-low pin
// sample and the acknowledge bits (ack_press, ack_release, ack_double,
// clear_all). Every input item produces exactly one result item with the
// debounced level, the three sticky event flags, the press length and the
// time stamp of the last press.
// Channels: input and output use valid/ready; an item moves on a rising edge
// with both high. Configuration is a plain write port (i_cfg_we, i_cfg_index,
// i_cfg_data); only the low 16 bits matter and an index past the last
// register is ignored. Write configuration only while the block is idle.
// Path: an accepted item sits in the input register until the output register
// is free or draining, is then evaluated by the state core and lands in the
// output register.
// Throughput: one item per cycle while the receiver keeps ready high. The only
// loop is the tick state update, made of compares and 32-bit subtractions.
// Stall: when the receiver holds ready low, the result stays in the output
// register, one more item waits in the input register, and then input ready
// drops; nothing is lost or repeated.
// Reset: synchronous, active low; both registers empty, the millisecond
// counter and all event state zero, registers back to 50/700/700.
`default_nettype none

module button_debounce_click_detector
    import bdc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic               i_pin_level,
    input  wire logic               i_ack_press,
    input  wire logic               i_ack_release,
    input  wire logic               i_ack_double,
    input  wire logic               i_clear_all,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic               o_held,
    output      logic               o_press_event,
    output      logic               o_release_event,
    output      logic               o_double_event,
    output      logic [TIME_W-1:0]  o_press_length,
    output      logic [TIME_W-1:0]  o_press_timestamp,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    t_cfg    r_cfg;
    t_result step_result;
    logic    step;
    logic    in_accept;

    // Advance the held item whenever the output register is free or draining
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item.pin_level   <= i_pin_level;
            r_in_item.ack_press   <= i_ack_press;
            r_in_item.ack_release <= i_ack_release;
            r_in_item.ack_double  <= i_ack_double;
            r_in_item.clear_all   <= i_clear_all;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= RST_DEBOUNCE_MS;
            r_cfg.click_window   <= RST_CLICK_WINDOW;
            r_cfg.double_timeout <= RST_DOUBLE_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE_MS:    r_cfg.debounce_ms    <= i_cfg_data;
                REG_CLICK_WINDOW:   r_cfg.click_window   <= i_cfg_data;
                REG_DOUBLE_TIMEOUT: r_cfg.double_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bdc_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Output register: load on step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_result <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_held            = r_out_result.held;
    assign o_press_event     = r_out_result.press_event;
    assign o_release_event   = r_out_result.release_event;
    assign o_double_event    = r_out_result.double_event;
    assign o_press_length    = r_out_result.press_length;
    assign o_press_timestamp = r_out_result.press_timestamp;

    a_step_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("evaluated item did not reach the output register");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input ready low with an empty input register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready && r_in_valid |-> !step && !o_in_ready)
        else $error("pipeline advanced into a stalled output register");

endmodule

`default_nettype wire

FILE: tb/bdc_result_check.sv
// Checker that predicts and compares every result item of the click detector.
module bdc_result_check
    import bdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire t_item             i_item,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_result           i_result,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_compared,
    output int                     o_presses,
    output int                     o_doubles
);

    t_cfg              timing;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] change_time;
    logic [TIME_W-1:0] press_start;
    logic [TIME_W-1:0] last_press;
    logic [TIME_W-1:0] last_duration;
    logic [TIME_W-1:0] last_click;
    logic              raw_prev;
    logic              held;
    logic              press_flag;
    logic              release_flag;
    logic              double_flag;
    logic [CLK_W-1:0]  clicks;
    t_result           button_reports[$];

    task automatic clear_events();
        press_flag    = 1'b0;
        release_flag  = 1'b0;
        last_duration = '0;
        clicks        = '0;
        double_flag   = 1'b0;
    endtask

    task automatic reset_state();
        timing.debounce_ms    = RST_DEBOUNCE_MS;
        timing.click_window   = RST_CLICK_WINDOW;
        timing.double_timeout = RST_DOUBLE_TIMEOUT;
        now_ms      = '0;
        raw_prev    = 1'b0;
        held        = 1'b0;
        change_time = '0;
        press_start = '0;
        last_press  = '0;
        last_click  = '0;
        clear_events();
        button_reports.delete();
        o_pending = 0;
    endtask

    // One millisecond tick: debounce, edges, report, then acknowledges.
    task automatic advance_millisecond(input t_item it, output t_result r);
        logic              raw;
        logic [TIME_W-1:0] gap;
        raw = ~it.pin_level;
        if (raw != raw_prev) begin
            change_time = now_ms;
            raw_prev    = raw;
        end
        gap = now_ms - change_time;
        if (gap > TIME_W'(timing.debounce_ms) && raw != held) begin
            held = raw;
            if (held) begin
                press_flag  = 1'b1;
                press_start = now_ms;
                last_press  = now_ms;
                o_presses++;
            end else begin
                release_flag  = 1'b1;
                last_duration = now_ms - press_start;
                gap = now_ms - last_click;
                if (gap < TIME_W'(timing.click_window)) begin
                    clicks = clicks + 1'b1;
                    if (clicks >= CLICKS_DOUBLE) begin
                        double_flag = 1'b1;
                        clicks      = '0;
                        o_doubles++;
                    end
                end else begin
                    clicks = 2'd1;
                end
                last_click = now_ms;
            end
        end

        r.held            = held;
        r.press_event     = press_flag;
        r.release_event   = release_flag;
        r.double_event    = double_flag;
        r.press_length    = held ? now_ms - press_start : last_duration;
        r.press_timestamp = last_press;

        if (it.ack_press) begin
            press_flag = 1'b0;
        end
        if (it.ack_release) begin
            release_flag = 1'b0;
        end
        if (it.ack_double) begin
            gap = now_ms - last_click;
            if (gap > TIME_W'(timing.double_timeout)) begin
                clicks = '0;
            end
            double_flag = 1'b0;
        end
        if (it.clear_all) begin
            clear_events();
        end
        now_ms = now_ms + 1'b1;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            reset_state();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DEBOUNCE_MS:    timing.debounce_ms    = i_cfg_data;
                    REG_CLICK_WINDOW:   timing.click_window   = i_cfg_data;
                    REG_DOUBLE_TIMEOUT: timing.double_timeout = i_cfg_data;
                    default: ;  // writes past the last register are dropped
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (button_reports.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    o_fail_count++;
                end else begin
                    want = button_reports.pop_front();
                    check_field("held", TIME_W'(want.held), TIME_W'(i_result.held));
                    check_field("press_event", TIME_W'(want.press_event),
                                TIME_W'(i_result.press_event));
                    check_field("release_event", TIME_W'(want.release_event),
                                TIME_W'(i_result.release_event));
                    check_field("double_event", TIME_W'(want.double_event),
                                TIME_W'(i_result.double_event));
                    check_field("press_length", want.press_length, i_result.press_length);
                    check_field("press_timestamp", want.press_timestamp,
                                i_result.press_timestamp);
                    o_compared++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_millisecond(i_item, want);
                button_reports.push_back(want);
            end
            o_pending = button_reports.size();
        end
    end

endmodule

FILE: tb/button_debounce_click_detector_test.sv
// Testbench top for the button debounce and click detector: stimulus and verdict.
module button_debounce_click_detector_test;
    import bdc_pkg::*;

    // Index past the last register; writes to it must be dropped by the block.
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    // Percentage of cycles in which each side holds back.
    localparam int IDLE_PCT = 27;
    // Percentage of ticks that carry each acknowledge bit.
    localparam int ACK_PCT  = 20;
    localparam int CLEAR_PCT = 3;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              pin_level   = 1'b1;
    logic              ack_press   = 1'b0;
    logic              ack_release = 1'b0;
    logic              ack_double  = 1'b0;
    logic              clear_all   = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              held;
    logic              press_event;
    logic              release_event;
    logic              double_event;
    logic [TIME_W-1:0] press_length;
    logic [TIME_W-1:0] press_timestamp;
    logic              cfg_we      = 1'b0;
    logic [IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_W-1:0]  cfg_data    = '0;

    int fail_count;
    int pending;
    int compared;
    int presses;
    int doubles;

    // Sender and receiver both stop idling while this is set.
    bit   calm = 1'b0;
    // Raw pin level of the current run and ticks left in it.
    logic level = 1'b1;
    int   run_left = 0;
    // Debounce time last written, to size the pin runs around it.
    int   debounce_now = int'(RST_DEBOUNCE_MS);
    int   ticks_sent = 0;
    int   settings = 0;

    button_debounce_click_detector dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_pin_level       (pin_level),
        .i_ack_press       (ack_press),
        .i_ack_release     (ack_release),
        .i_ack_double      (ack_double),
        .i_clear_all       (clear_all),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_held            (held),
        .o_press_event     (press_event),
        .o_release_event   (release_event),
        .o_double_event    (double_event),
        .o_press_length    (press_length),
        .o_press_timestamp (press_timestamp),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    bdc_result_check result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_item       ({pin_level, ack_press, ack_release, ack_double, clear_all}),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_result     ({held, press_event, release_event, double_event,
                        press_length, press_timestamp}),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_presses    (presses),
        .o_doubles    (doubles)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random, except during calm stretches.
    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Write one register; hold the enable for a single edge.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_timing(input int deb, input int win, input int dto);
        write_reg(REG_DEBOUNCE_MS, CFG_W'(deb));
        write_reg(REG_CLICK_WINDOW, CFG_W'(win));
        write_reg(REG_DOUBLE_TIMEOUT, CFG_W'(dto));
        debounce_now = deb;
        settings++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // Offer one millisecond tick and hold it until the block takes it.
    task automatic send_tick(input logic pin, input logic ap, input logic ar,
                             input logic ad, input logic ca);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        pin_level   <= pin;
        ack_press   <= ap;
        ack_release <= ar;
        ack_double  <= ad;
        clear_all   <= ca;
        do begin
            @(posedge clk);
        end while (!in_ready);
        ticks_sent++;
    endtask

    // Drive pin runs mostly long enough to pass a debounce of up to 64, with some
    // bounces that must be filtered, plus random acknowledges; above 64, only bounces.
    task automatic random_ticks(input int count);
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                level = ~level;
                if (debounce_now > 64) begin
                    run_left = $urandom_range(1, 4);
                end else if ($urandom_range(99) < 15) begin
                    run_left = $urandom_range(1, debounce_now + 1);
                end else begin
                    run_left = $urandom_range(debounce_now + 2, debounce_now + 12);
                end
            end
            run_left--;
            send_tick(level,
                      $urandom_range(99) < ACK_PCT,
                      $urandom_range(99) < ACK_PCT,
                      $urandom_range(99) < ACK_PCT,
                      $urandom_range(99) < CLEAR_PCT);
        end
    endtask

    initial begin : stimulus
        int deb;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: zero debounce, so a level is taken on its second tick.
        set_timing(0, 8, 2);
        write_reg(REG_SPARE, '1);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // press taken
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // acknowledge the press
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // release right after reset clicks
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // second click: double
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);  // ack inside the timeout
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // one-tick bounce
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0);  // ack past the timeout
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);  // clear everything while held
        send_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);  // every acknowledge at once
        drain();

        // Random part, one register setting per phase; extremes come first.
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin
                    calm = 1'b1;  // long stretch with no idling on either side
                    set_timing(0, 65535, 65535);
                end
                1: set_timing(0, 0, 0);
                2: set_timing(65535, 65535, 0);
                default: begin
                    deb = $urandom_range(0, 6);
                    set_timing(deb, $urandom_range(0, 4 * (deb + 10)),
                               $urandom_range(0, 4 * (deb + 10)));
                end
            endcase
            if (p == 2) begin
                random_ticks(20);  // long debounce: nothing may ever settle
            end else if (p == 4) begin
                // Hold the sender mid-phase until the block has emptied.
                random_ticks(55);
                drain();
                random_ticks(55);
            end else begin
                random_ticks(110);
            end
            drain();
            calm = 1'b0;
        end

        // Let more edges pass to catch any stray result item.
        repeat (8) @(posedge clk);
        $display("Covered %0d ticks under %0d register settings; %0d results compared.",
                 ticks_sent, settings, compared);
        $display("Predicted %0d debounced presses and %0d double clicks.", presses, doubles);
        if (fail_count == 0) begin
            $display("[button_debounce_click_detector] OK");
        end else begin
            $display("[button_debounce_click_detector] ERROR");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #2000000;
        $display("[button_debounce_click_detector] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bdc_pkg.sv
hw/rtl/bdc_state.sv
hw/rtl/button_debounce_click_detector.sv
tb/bdc_result_check.sv
tb/button_debounce_click_detector_test.sv
